// File: rtl/assert_macros.svh
// assertion macros shared by the deframer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// File: rtl/c32dfr_pkg.sv
// shared types, codes and the crc helper for the crc32 message deframer
package c32dfr_pkg;

    // verdict codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_INCOMPLETE = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC  = 3'd2;
    localparam logic [2:0] ST_BAD_VER    = 3'd3;
    localparam logic [2:0] ST_TOO_LONG   = 3'd4;
    localparam logic [2:0] ST_CRC_ERR    = 3'd5;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_MAGIC   = 2'd0;
    localparam logic [1:0] CFG_VERSION = 2'd1;
    localparam logic [1:0] CFG_MAX_LEN = 2'd2;

    // reset values of the configuration registers
    localparam logic [31:0] RST_MAGIC   = 32'd0;
    localparam logic [7:0]  RST_VERSION = 8'd1;
    localparam logic [31:0] RST_MAX_LEN = 32'd33554432;

    // frame geometry
    localparam logic [31:0] HDR_BYTES = 32'd14;
    localparam logic [31:0] CRC_BYTES = 32'd4;
    localparam logic [31:0] MIN_BUF   = 32'd18;

    // crc-32, reflected form
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // one classified request: optional payload result, optional verdict result
    typedef struct packed {
        logic        pay_en;
        logic [7:0]  pay_byte;
        logic        ver_en;
        logic [2:0]  status;
        logic [7:0]  msg_type;
        logic [31:0] length;
    } t_cmd;

    // one byte through the crc register, lsb first
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

// File: rtl/c32dfr_front.sv
// front end: header parser, crc and verdict classification per byte
module c32dfr_front
    import c32dfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_accept,
    input  logic [7:0]  i_in_byte,
    input  logic        i_eob,
    output logic        o_push,
    output t_cmd        o_cmd
);

    // parser phases
    localparam logic [2:0] PH_HEADER     = 3'd0;
    localparam logic [2:0] PH_PAYLOAD    = 3'd1;
    localparam logic [2:0] PH_CRC        = 3'd2;
    localparam logic [2:0] PH_DONE       = 3'd3;
    localparam logic [2:0] PH_HOLD_MAGIC = 3'd4;
    localparam logic [2:0] PH_HOLD_VER   = 3'd5;
    localparam logic [2:0] PH_HOLD_LEN   = 3'd6;

    logic [31:0] r_cfg_magic;
    logic [7:0]  r_cfg_version;
    logic [31:0] r_cfg_max;

    logic [2:0]  r_phase,   n_phase;
    logic [31:0] r_count,   n_count;
    logic [31:0] r_magic,   n_magic;
    logic [7:0]  r_version, n_version;
    logic [7:0]  r_type,    n_type;
    logic [31:0] r_len,     n_len;
    logic        r_len_hi,  n_len_hi;
    logic [31:0] r_crc,     n_crc;
    logic [31:0] r_rx,      n_rx;

    logic [31:0] cnt_inc;
    logic        ver_now;
    logic        crc_good;
    t_cmd        cmd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_magic   <= RST_MAGIC;
            r_cfg_version <= RST_VERSION;
            r_cfg_max     <= RST_MAX_LEN;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MAGIC:   r_cfg_magic   <= i_cfg_data;
                CFG_VERSION: r_cfg_version <= i_cfg_data[7:0];
                CFG_MAX_LEN: r_cfg_max     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-byte parse and classification
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_magic   = r_magic;
        n_version = r_version;
        n_type    = r_type;
        n_len     = r_len;
        n_len_hi  = r_len_hi;
        n_crc     = r_crc;
        n_rx      = r_rx;
        cnt_inc   = r_count + 32'd1;
        ver_now   = 1'b0;
        crc_good  = 1'b0;
        cmd       = '0;
        if (i_accept) begin
            case (r_phase)
                PH_HEADER: begin
                    n_crc   = crc_byte(r_crc, i_in_byte);
                    n_count = cnt_inc;
                    if (r_count < 32'd4) begin
                        n_magic = {r_magic[23:0], i_in_byte};
                    end else if (r_count == 32'd4) begin
                        n_version = i_in_byte;
                    end else if (r_count == 32'd5) begin
                        n_type = i_in_byte;
                    end else begin
                        n_len = {r_len[23:0], i_in_byte};
                        // first four length bytes form the upper word
                        if (r_count < 32'd10 && i_in_byte != 8'd0) begin
                            n_len_hi = 1'b1;
                        end
                    end
                    if (cnt_inc == HDR_BYTES) begin
                        if (n_magic != r_cfg_magic) begin
                            n_phase = PH_HOLD_MAGIC;
                        end else if (n_version != r_cfg_version) begin
                            n_phase = PH_HOLD_VER;
                        end else if (n_len_hi || n_len > r_cfg_max) begin
                            n_phase = PH_HOLD_LEN;
                        end else begin
                            n_phase = (n_len == 32'd0) ? PH_CRC : PH_PAYLOAD;
                            n_count = 32'd0;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_crc        = crc_byte(r_crc, i_in_byte);
                    cmd.pay_en   = 1'b1;
                    cmd.pay_byte = i_in_byte;
                    n_count      = cnt_inc;
                    if (cnt_inc == r_len) begin
                        n_phase = PH_CRC;
                        n_count = 32'd0;
                    end
                end
                PH_CRC: begin
                    n_rx    = {r_rx[23:0], i_in_byte};
                    n_count = cnt_inc;
                    if (cnt_inc == CRC_BYTES) begin
                        crc_good     = ((r_crc ^ CRC_INIT) == n_rx);
                        cmd.ver_en   = 1'b1;
                        cmd.status   = crc_good ? ST_OK : ST_CRC_ERR;
                        cmd.msg_type = r_type;
                        cmd.length   = crc_good ? r_len : 32'd0;
                        n_phase      = PH_DONE;
                        ver_now      = 1'b1;
                    end
                end
                PH_HOLD_MAGIC, PH_HOLD_VER, PH_HOLD_LEN: begin
                    // bad header waits for the minimum buffer size
                    n_count = cnt_inc;
                    if (cnt_inc >= MIN_BUF) begin
                        cmd.ver_en   = 1'b1;
                        cmd.msg_type = r_type;
                        case (r_phase)
                            PH_HOLD_MAGIC: cmd.status = ST_BAD_MAGIC;
                            PH_HOLD_VER:   cmd.status = ST_BAD_VER;
                            default:       cmd.status = ST_TOO_LONG;
                        endcase
                        n_phase = PH_DONE;
                        ver_now = 1'b1;
                    end
                end
                default: ;
            endcase
            // end of buffer closes the message
            if (i_eob) begin
                if (r_phase != PH_DONE && !ver_now) begin
                    cmd.ver_en   = 1'b1;
                    cmd.status   = ST_INCOMPLETE;
                    cmd.msg_type = n_type;
                    cmd.length   = 32'd0;
                end
                n_phase   = PH_HEADER;
                n_count   = 32'd0;
                n_magic   = 32'd0;
                n_version = 8'd0;
                n_type    = 8'd0;
                n_len     = 32'd0;
                n_len_hi  = 1'b0;
                n_crc     = CRC_INIT;
                n_rx      = 32'd0;
            end
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_count   <= 32'd0;
            r_magic   <= 32'd0;
            r_version <= 8'd0;
            r_type    <= 8'd0;
            r_len     <= 32'd0;
            r_len_hi  <= 1'b0;
            r_crc     <= CRC_INIT;
            r_rx      <= 32'd0;
        end else begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_magic   <= n_magic;
            r_version <= n_version;
            r_type    <= n_type;
            r_len     <= n_len;
            r_len_hi  <= n_len_hi;
            r_crc     <= n_crc;
            r_rx      <= n_rx;
        end
    end

    assign o_push = cmd.pay_en | cmd.ver_en;
    assign o_cmd  = cmd;

endmodule

// File: rtl/c32dfr_queue.sv
// short command queue between the front and back ends
module c32dfr_queue
    import c32dfr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_cmd   i_cmd,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_cmd   o_cmd
);

`include "assert_macros.svh"

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QAW:0]   r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_CLK(a_count_bound, r_count <= (QAW+1)'(QDEPTH), "queue count beyond depth")
    `ASSERT_CLK(a_pop_drains, (do_pop && !do_push) |=> (r_count + 1'b1) == $past(r_count),
        "pop without push did not lower the count")

endmodule

// File: rtl/c32dfr_back.sv
// back end: expands queued requests into result items on the output register
module c32dfr_back
    import c32dfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_cmd        i_q_cmd,
    output logic        o_q_pop,
    input  logic        i_pop,
    output logic        o_empty,
    output logic        o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [2:0]  o_status,
    output logic [7:0]  o_msg_type,
    output logic [31:0] o_payload_length,
    output logic        o_last
);

`include "assert_macros.svh"

    logic        r_out_valid;
    logic        r_kind;
    logic [7:0]  r_pbyte;
    logic [2:0]  r_status;
    logic [7:0]  r_type;
    logic [31:0] r_len;
    logic        r_pend;
    logic [2:0]  r_pend_status;
    logic [7:0]  r_pend_type;
    logic [31:0] r_pend_len;
    logic        out_free;

    assign out_free = !r_out_valid || i_pop;
    assign o_q_pop  = out_free && !r_pend && !i_q_empty;

    // result valid and pending verdict control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else if (out_free) begin
            if (r_pend) begin
                r_out_valid <= 1'b1;
                r_pend      <= 1'b0;
            end else if (!i_q_empty) begin
                r_out_valid <= 1'b1;
                r_pend      <= i_q_cmd.pay_en && i_q_cmd.ver_en;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_pend) begin
                r_kind   <= KIND_VERDICT;
                r_pbyte  <= 8'd0;
                r_status <= r_pend_status;
                r_type   <= r_pend_type;
                r_len    <= r_pend_len;
            end else if (!i_q_empty) begin
                if (i_q_cmd.pay_en) begin
                    r_kind   <= KIND_PAYLOAD;
                    r_pbyte  <= i_q_cmd.pay_byte;
                    r_status <= ST_OK;
                    r_type   <= 8'd0;
                    r_len    <= 32'd0;
                end else begin
                    r_kind   <= KIND_VERDICT;
                    r_pbyte  <= 8'd0;
                    r_status <= i_q_cmd.status;
                    r_type   <= i_q_cmd.msg_type;
                    r_len    <= i_q_cmd.length;
                end
                r_pend_status <= i_q_cmd.status;
                r_pend_type   <= i_q_cmd.msg_type;
                r_pend_len    <= i_q_cmd.length;
            end
        end
    end

    assign o_empty          = !r_out_valid;
    assign o_kind           = r_kind;
    assign o_payload_byte   = r_pbyte;
    assign o_status         = r_status;
    assign o_msg_type       = r_type;
    assign o_payload_length = r_len;
    assign o_last           = (r_kind == KIND_VERDICT);

    `ASSERT_CLK(a_pend_has_payload, r_pend |-> (r_out_valid && r_kind == KIND_PAYLOAD),
        "pending verdict without a payload result in front of it")
    `ASSERT_CLK(a_no_pop_while_pend, r_pend |-> !o_q_pop,
        "queue popped while a verdict is still pending")

endmodule

// File: rtl/crc32_message_deframer.sv
// top level of the crc32 message deframer: front end, command queue, back end
// Usage:
//   Bytes of a receive buffer enter on i_in_byte with i_end_of_buffer high on
//   the last byte; a byte is taken on a clock edge with push high and full low.
//   Results leave as a queue: while empty is low the oldest result is on the
//   o_ ports and is taken on an edge with pop high. A result is either a
//   payload byte (o_kind low) or the single verdict closing the buffer
//   (o_kind high, o_last high).
//   Configuration (magic, version, maximum payload) is written through
//   i_cfg_wr_en / i_cfg_index / i_cfg_data while the block is idle.
// Timing:
//   A byte is classified in the cycle it is taken and queued at that edge; its
//   first result is then loaded from the queue into the output register once
//   that register is free and earlier requests have left. One byte per cycle is
//   sustained while full stays low; a byte that gives both a payload result and
//   a verdict fills the single output register of the back end twice, payload first.
// Reset and stalls:
//   Synchronous active-low reset clears the parser, the queue and the output
//   and loads the register defaults. When pop is held low the four-entry queue
//   fills and full rises; no result is lost or repeated.
module crc32_message_deframer
    import c32dfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_buffer,
    output logic        empty,
    input  logic        pop,
    output logic        o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [2:0]  o_status,
    output logic [7:0]  o_msg_type,
    output logic [31:0] o_payload_length,
    output logic        o_last
);

    logic accept;
    logic f_push;
    t_cmd f_cmd;
    logic q_empty;
    logic q_pop;
    t_cmd q_cmd;

    assign accept = push && !full;

    // byte parser
    c32dfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_in_byte   (i_in_byte),
        .i_eob       (i_end_of_buffer),
        .o_push      (f_push),
        .o_cmd       (f_cmd)
    );

    // decoupling queue
    c32dfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    // result expansion and output register
    c32dfr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_q_cmd          (q_cmd),
        .o_q_pop          (q_pop),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_kind           (o_kind),
        .o_payload_byte   (o_payload_byte),
        .o_status         (o_status),
        .o_msg_type       (o_msg_type),
        .o_payload_length (o_payload_length),
        .o_last           (o_last)
    );

endmodule
